// ----- src/time_sorted_entry_table_assert.svh -----
// Assertion macros for the time-sorted entry table.
// Included by the top level, which checks its own sequencing; no other dependencies.
`ifndef TIME_SORTED_ENTRY_TABLE_ASSERT_SVH
`define TIME_SORTED_ENTRY_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Immediate-cycle property, disabled while reset is asserted.
`define TSET_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed in %m");
// Next-cycle implication, disabled while reset is asserted.
`define TSET_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed in %m");
`else
`define TSET_ASSERT(lbl, clk, rstn, prop)
`define TSET_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// ----- src/tset_pkg.sv -----
// Shared constants, codes and the stored entry type of the time-sorted entry table.
// No dependencies; imported by the key comparator, the top level and the testbench.
package tset_pkg;

    // Table sizing.
    localparam int CAPACITY = 32;
    localparam int TAG_BITS = 16;
    localparam int TAG_KEEP = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1) > 0 ? $clog2(CAPACITY + 1) : 1;

    // Field limits.
    localparam int MONTH_MAX  = 12;
    localparam int DAY_MAX    = 31;
    localparam int HOURS_MAX  = 23;
    localparam int MINUTE_MAX = 59;

    // Operation codes.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef logic [2:0] t_status;

    // Result status codes.
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_MONTH = 3'd1;
    localparam t_status ST_BAD_DAY   = 3'd2;
    localparam t_status ST_BAD_TIME  = 3'd3;
    localparam t_status ST_FULL      = 3'd4;
    localparam t_status ST_LISTED    = 3'd5;
    localparam t_status ST_EMPTY     = 3'd6;

    // One stored entry; the leading fields form the sort key.
    typedef struct packed {
        logic [3:0]          month;
        logic [4:0]          day;
        logic [4:0]          hours;
        logic [5:0]          minutes;
        logic [TAG_KEEP-1:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ----- src/tset_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; a read in the same cycle sees old data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/tset_key_cmp.sv -----
// Key comparator shared by every step of the insertion walk.
// Depends on tset_pkg for the entry type.
module tset_key_cmp (
    input  tset_pkg::t_entry i_new,
    input  tset_pkg::t_entry i_held,
    output logic             o_less
);
    import tset_pkg::*;

    logic [19:0] new_key;
    logic [19:0] held_key;

    // The key orders by month, then day, hour and minute.
    assign new_key  = {i_new.month, i_new.day, i_new.hours, i_new.minutes};
    assign held_key = {i_held.month, i_held.day, i_held.hours, i_held.minutes};

    // Strictly less, so an equal key lands after the entries already held.
    assign o_less = (new_key < held_key);

endmodule

// ----- src/time_sorted_entry_table.sv -----
// Top level of the time-sorted entry table: sequencer, field checks and result register.
// Depends on tset_pkg, tset_ram, tset_key_cmp and the assertion macro header.
`include "time_sorted_entry_table_assert.svh"

// The table holds up to CAPACITY timed entries in one RAM, kept sorted by month, day,
// hour and minute, with equal keys in arrival order. A rejected insert (full table or a
// bad field) or an insert into an empty table is done on acceptance. Any other insert
// walks the table past every held entry with a greater key: a single key
// comparator walks the table from the tail, reading one entry and moving it up one
// place per cycle through the RAM's read and write ports. The insert result is given
// at once on acceptance; the next request is taken when the walk is done. A finish
// request lists one entry per cycle while the sink takes them, and then empties the
// table. No clearing pass is needed after reset.
module time_sorted_entry_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [6:0]         i_month,
    input  logic [6:0]         i_day,
    input  logic [6:0]         i_hours,
    input  logic [6:0]         i_minutes,
    input  logic [15:0]        i_tag,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tset_pkg::t_status  o_status,
    output logic [3:0]         o_out_month,
    output logic [4:0]         o_out_day,
    output logic [4:0]         o_out_hours,
    output logic [5:0]         o_out_minutes,
    output logic [15:0]        o_out_tag,
    output logic               o_last
);
    import tset_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEEK = 2'd1;
    localparam logic [1:0] S_HEAD = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_count, n_count;
    t_entry           r_new, n_new;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    t_entry           r_out_entry, n_out_entry;
    logic             r_out_last, n_out_last;

    logic             out_free;
    logic             accept;
    logic             full;
    logic             list_last;
    logic             key_less;
    t_status          chk_status;
    t_entry           in_entry;
    t_entry           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign list_last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // Incoming entry as it would be stored.
    assign in_entry.month   = i_month[3:0];
    assign in_entry.day     = i_day[4:0];
    assign in_entry.hours   = i_hours[4:0];
    assign in_entry.minutes = i_minutes[5:0];
    assign in_entry.tag     = i_tag[TAG_KEEP-1:0];

    // Insert checks: a full table first, then month, day and time in that order.
    always_comb begin
        if (full) begin
            chk_status = ST_FULL;
        end else if (i_month == 7'd0 || i_month > 7'(MONTH_MAX)) begin
            chk_status = ST_BAD_MONTH;
        end else if (i_day == 7'd0 || i_day > 7'(DAY_MAX)) begin
            chk_status = ST_BAD_DAY;
        end else if (i_hours > 7'(HOURS_MAX) || i_minutes > 7'(MINUTE_MAX)) begin
            chk_status = ST_BAD_TIME;
        end else begin
            chk_status = ST_OK;
        end
    end

    // Entry store; the read address follows the next index so data tracks r_idx.
    tset_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (n_idx),
        .o_rd_data (rd_data)
    );

    // Shared comparator between the pending entry and the one just read.
    tset_key_cmp u_cmp (
        .i_new  (r_new),
        .i_held (rd_data),
        .o_less (key_less)
    );

    // Sequencer and result loading.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_new        = r_new;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = IDX_W'(r_idx + 1'b1);
        wr_data      = r_new;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_FINISH) begin
                        if (r_count == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_EMPTY;
                            n_out_entry  = '0;
                            n_out_last   = 1'b1;
                        end else begin
                            n_idx   = '0;
                            n_state = S_LIST;
                        end
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = chk_status;
                        n_out_entry  = '0;
                        n_out_last   = 1'b1;
                        if (chk_status == ST_OK) begin
                            n_new = in_entry;
                            if (r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_addr = '0;
                                wr_data = in_entry;
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_idx   = IDX_W'(r_count - CNT_W'(1));
                                n_state = S_SEEK;
                            end
                        end
                    end
                end
            end
            S_SEEK: begin
                // Move a greater entry up one place, or drop the new one in above it.
                wr_en = 1'b1;
                if (key_less) begin
                    wr_data = rd_data;
                    if (r_idx == '0) begin
                        n_state = S_HEAD;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_state = S_IDLE;
                end
            end
            S_HEAD: begin
                // Every held entry had a greater key: the new one goes first.
                wr_en   = 1'b1;
                wr_addr = '0;
                n_count = r_count + CNT_W'(1);
                n_state = S_IDLE;
            end
            S_LIST: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_LISTED;
                    n_out_entry  = rd_data;
                    n_out_last   = list_last;
                    if (list_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_new        <= n_new;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_month   = r_out_entry.month;
    assign o_out_day     = r_out_entry.day;
    assign o_out_hours   = r_out_entry.hours;
    assign o_out_minutes = r_out_entry.minutes;
    assign o_out_tag     = 16'(r_out_entry.tag);
    assign o_last        = r_out_last;

    // Sequencing checks.
    `TSET_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY))
    `TSET_ASSERT(a_seek_nonempty, i_clk, i_rst_n, (r_state == S_SEEK) |-> (r_count != '0))
    `TSET_ASSERT(a_write_in_range, i_clk, i_rst_n, wr_en |-> (CNT_W'(wr_addr) <= r_count))
    `TSET_ASSERT_NEXT(a_list_drains, i_clk, i_rst_n, (r_state == S_LIST) && out_free && list_last, (r_count == '0) && (r_state == S_IDLE))

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for time_sorted_entry_table: directed requests, then random episodes.
// Depends on tset_pkg and the time_sorted_entry_table top level.
module tb;
    import tset_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 80;
    localparam int DIRECTED_ROWS = 22;

    // One result of the block, field by field.
    typedef struct packed {
        t_status     status;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [15:0] tag;
        logic        last;
    } t_table_result;

    // One directed request, with a hand-written status where it is obvious.
    typedef struct packed {
        logic        func;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hours;
        logic [6:0]  minutes;
        logic [15:0] tag;
        bit          typed;
        t_status     typed_status;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_func;
    logic [6:0]  i_month;
    logic [6:0]  i_day;
    logic [6:0]  i_hours;
    logic [6:0]  i_minutes;
    logic [15:0] i_tag;
    logic        o_out_valid;
    logic        i_out_ready;
    t_status     o_status;
    logic [3:0]  o_out_month;
    logic [4:0]  o_out_day;
    logic [4:0]  o_out_hours;
    logic [5:0]  o_out_minutes;
    logic [15:0] o_out_tag;
    logic        o_last;

    // Shadow copy of the sorted table.
    t_entry sched_store [CAPACITY];
    int     sched_count;

    t_table_result step_results [$];
    t_table_result pending_results [$];

    bit      drv_typed;
    t_status drv_typed_status;
    bit      long_hold_req;
    int      burst_left;
    int      mismatch_count;
    int      idle_cycles;

    t_stim_row directed_rows [DIRECTED_ROWS];

    time_sorted_entry_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_month       (i_month),
        .i_day         (i_day),
        .i_hours       (i_hours),
        .i_minutes     (i_minutes),
        .i_tag         (i_tag),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_out_month   (o_out_month),
        .o_out_day     (o_out_day),
        .o_out_hours   (o_out_hours),
        .o_out_minutes (o_out_minutes),
        .o_out_tag     (o_out_tag),
        .o_last        (o_last)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Work out the results of one accepted request and update the shadow table.
    task automatic predict_table_step(input logic func, input logic [6:0] month,
                                      input logic [6:0] day, input logic [6:0] hours,
                                      input logic [6:0] minutes, input logic [15:0] tag);
        t_entry        fresh;
        t_table_result r;
        int            pos;
        step_results.delete();
        r = '0;
        r.last = 1'b1;
        if (func == FUNC_FINISH) begin
            if (sched_count == 0) begin
                r.status = ST_EMPTY;
                step_results.push_back(r);
            end else begin
                for (int i = 0; i < sched_count; i++) begin
                    r = '0;
                    r.status  = ST_LISTED;
                    r.month   = sched_store[i].month;
                    r.day     = sched_store[i].day;
                    r.hours   = sched_store[i].hours;
                    r.minutes = sched_store[i].minutes;
                    r.tag[TAG_KEEP-1:0] = sched_store[i].tag;
                    r.last    = (i == sched_count - 1);
                    step_results.push_back(r);
                end
                sched_count = 0;
            end
        end else if (sched_count >= CAPACITY) begin
            r.status = ST_FULL;
            step_results.push_back(r);
        end else if (month < 1 || month > MONTH_MAX) begin
            r.status = ST_BAD_MONTH;
            step_results.push_back(r);
        end else if (day < 1 || day > DAY_MAX) begin
            r.status = ST_BAD_DAY;
            step_results.push_back(r);
        end else if (hours > HOURS_MAX || minutes > MINUTE_MAX) begin
            r.status = ST_BAD_TIME;
            step_results.push_back(r);
        end else begin
            fresh.month   = month[3:0];
            fresh.day     = day[4:0];
            fresh.hours   = hours[4:0];
            fresh.minutes = minutes[5:0];
            fresh.tag     = tag[TAG_KEEP-1:0];
            // Equal keys go after the entries already held.
            pos = 0;
            while (pos < sched_count &&
                   !({fresh.month, fresh.day, fresh.hours, fresh.minutes} <
                     {sched_store[pos].month, sched_store[pos].day,
                      sched_store[pos].hours, sched_store[pos].minutes}))
                pos++;
            for (int i = sched_count; i > pos; i--)
                sched_store[i] = sched_store[i-1];
            sched_store[pos] = fresh;
            sched_count++;
            r.status = ST_OK;
            step_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Offer one request and hold it until taken; the sender idles between bursts.
    task automatic offer(input logic func, input logic [6:0] month, input logic [6:0] day,
                         input logic [6:0] hours, input logic [6:0] minutes,
                         input logic [15:0] tag, input bit typed, input t_status typed_status);
        int gap;
        @(negedge i_clk);
        i_in_valid       = 1'b1;
        i_func           = func;
        i_month          = month;
        i_day            = day;
        i_hours          = hours;
        i_minutes        = minutes;
        i_tag            = tag;
        drv_typed        = typed;
        drv_typed_status = typed_status;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Insert request; well-formed ones lean on corner values so equal keys are common.
    task automatic offer_random_insert(input bit well_formed);
        logic [6:0] month, day, hours, minutes;
        if (well_formed && $urandom_range(0, 1) == 1) begin
            month   = $urandom_range(0, 1) ? 7'd1 : 7'd12;
            day     = $urandom_range(0, 1) ? 7'd1 : 7'd31;
            hours   = $urandom_range(0, 1) ? 7'd0 : 7'd23;
            minutes = $urandom_range(0, 1) ? 7'd0 : 7'd59;
        end else if (well_formed) begin
            month   = 7'($urandom_range(1, 12));
            day     = 7'($urandom_range(1, 31));
            hours   = 7'($urandom_range(0, 23));
            minutes = 7'($urandom_range(0, 59));
        end else begin
            month   = 7'($urandom_range(0, 99));
            day     = 7'($urandom_range(0, 99));
            hours   = 7'($urandom_range(0, 99));
            minutes = 7'($urandom_range(0, 99));
        end
        offer(FUNC_INSERT, month, day, hours, minutes, 16'($urandom), 1'b0, ST_OK);
    endtask

    // Lower valid and wait until every expected result has come back.
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Predict on each accepted request, then check each accepted result.
    always @(posedge i_clk) begin : result_check
        t_table_result want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_table_step(i_func, i_month, i_day, i_hours, i_minutes, i_tag);
                if (drv_typed) begin
                    want = '0;
                    want.status = drv_typed_status;
                    want.last   = 1'b1;
                    pending_results.push_back(want);
                end else begin
                    foreach (step_results[k]) pending_results.push_back(step_results[k]);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with none expected, status", int'(o_status), -1);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", int'(o_status), int'(want.status));
                    if (o_out_month !== want.month)
                        report_mismatch("out_month", int'(o_out_month), int'(want.month));
                    if (o_out_day !== want.day)
                        report_mismatch("out_day", int'(o_out_day), int'(want.day));
                    if (o_out_hours !== want.hours)
                        report_mismatch("out_hours", int'(o_out_hours), int'(want.hours));
                    if (o_out_minutes !== want.minutes)
                        report_mismatch("out_minutes", int'(o_out_minutes),
                                        int'(want.minutes));
                    if (o_out_tag !== want.tag)
                        report_mismatch("out_tag", int'(o_out_tag), int'(want.tag));
                    if (o_last !== want.last)
                        report_mismatch("last", int'(o_last), int'(want.last));
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result sink: changing stall patterns, plus one long hold on request.
    initial begin : result_sink
        int mode;
        int mode_left;
        i_out_ready = 1'b0;
        mode = 0;
        mode_left = 0;
        forever begin
            if (long_hold_req) begin
                @(negedge i_clk);
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else begin
                if (mode_left <= 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                @(negedge i_clk);
                case (mode)
                    0: begin
                        i_out_ready = 1'b1;
                    end
                    1: begin
                        i_out_ready = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_out_ready = ($urandom_range(0, 3) == 0);
                    end
                endcase
                mode_left--;
            end
        end
    end

    // Stimulus: reset, directed table, then random episodes of inserts and finishes.
    initial begin : stimulus
        int  random_items;
        int  ep;
        int  n;
        bit  big;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_func           = FUNC_INSERT;
        i_month          = '0;
        i_day            = '0;
        i_hours          = '0;
        i_minutes        = '0;
        i_tag            = '0;
        drv_typed        = 1'b0;
        drv_typed_status = ST_OK;
        long_hold_req    = 1'b0;
        burst_left       = 4;
        mismatch_count   = 0;
        idle_cycles      = 0;
        sched_count      = 0;
        random_items     = 0;

        directed_rows = '{
            // Finish right after reset: empty list.
            '{FUNC_FINISH, 7'd0,  7'd0,  7'd0,  7'd0,  16'h0000, 1'b1, ST_EMPTY},
            // Month checks, including month zero and month before day.
            '{FUNC_INSERT, 7'd0,  7'd15, 7'd12, 7'd30, 16'h0001, 1'b1, ST_BAD_MONTH},
            '{FUNC_INSERT, 7'd13, 7'd0,  7'd12, 7'd30, 16'h0002, 1'b1, ST_BAD_MONTH},
            '{FUNC_INSERT, 7'd99, 7'd99, 7'd99, 7'd99, 16'hFFFF, 1'b1, ST_BAD_MONTH},
            // Day checks, including day zero and day before time.
            '{FUNC_INSERT, 7'd12, 7'd0,  7'd0,  7'd0,  16'h0003, 1'b1, ST_BAD_DAY},
            '{FUNC_INSERT, 7'd1,  7'd32, 7'd99, 7'd99, 16'h0004, 1'b1, ST_BAD_DAY},
            '{FUNC_INSERT, 7'd1,  7'd99, 7'd0,  7'd0,  16'h0005, 1'b1, ST_BAD_DAY},
            // Time checks.
            '{FUNC_INSERT, 7'd1,  7'd1,  7'd24, 7'd0,  16'h0006, 1'b1, ST_BAD_TIME},
            '{FUNC_INSERT, 7'd1,  7'd1,  7'd0,  7'd60, 16'h0007, 1'b1, ST_BAD_TIME},
            '{FUNC_INSERT, 7'd12, 7'd31, 7'd99, 7'd99, 16'h0008, 1'b1, ST_BAD_TIME},
            // Good inserts at the extremes and with equal keys.
            '{FUNC_INSERT, 7'd12, 7'd31, 7'd23, 7'd59, 16'hFFFF, 1'b1, ST_OK},
            '{FUNC_INSERT, 7'd1,  7'd1,  7'd0,  7'd0,  16'h0000, 1'b1, ST_OK},
            '{FUNC_INSERT, 7'd6,  7'd15, 7'd12, 7'd30, 16'h1234, 1'b1, ST_OK},
            '{FUNC_INSERT, 7'd6,  7'd15, 7'd12, 7'd30, 16'h5678, 1'b1, ST_OK},
            '{FUNC_INSERT, 7'd1,  7'd1,  7'd0,  7'd0,  16'hAAAA, 1'b1, ST_OK},
            '{FUNC_INSERT, 7'd12, 7'd31, 7'd23, 7'd59, 16'h5555, 1'b1, ST_OK},
            '{FUNC_INSERT, 7'd6,  7'd15, 7'd12, 7'd29, 16'h0F0F, 1'b1, ST_OK},
            '{FUNC_INSERT, 7'd7,  7'd1,  7'd0,  7'd0,  16'h8001, 1'b0, ST_OK},
            // Finish with junk in the ignored fields lists everything.
            '{FUNC_FINISH, 7'd99, 7'd99, 7'd99, 7'd99, 16'hFFFF, 1'b0, ST_OK},
            '{FUNC_FINISH, 7'd0,  7'd0,  7'd0,  7'd0,  16'h0000, 1'b1, ST_EMPTY},
            '{FUNC_INSERT, 7'd3,  7'd28, 7'd16, 7'd44, 16'h7E81, 1'b0, ST_OK},
            '{FUNC_FINISH, 7'd12, 7'd31, 7'd23, 7'd59, 16'h1234, 1'b0, ST_OK}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r])
            offer(directed_rows[r].func, directed_rows[r].month, directed_rows[r].day,
                  directed_rows[r].hours, directed_rows[r].minutes, directed_rows[r].tag,
                  directed_rows[r].typed, directed_rows[r].typed_status);
        wait_results_drained();

        // Random episodes: a run of inserts normally closed by a finish.
        ep = 0;
        while (random_items < RANDOM_ITEMS) begin
            big = (ep < 2) || ($urandom_range(0, 4) == 0);
            n = big ? $urandom_range(36, 44) : $urandom_range(0, 10);
            // The second episode offers more inserts than the table holds, starting with a long hold at the sink.
            if (ep == 1)
                long_hold_req = 1'b1;
            for (int k = 0; k < n; k++) begin
                if (ep == 0)
                    offer_random_insert(1'b1);
                else if (big)
                    offer_random_insert($urandom_range(0, 9) != 0);
                else
                    offer_random_insert($urandom_range(0, 9) >= 3);
                random_items++;
            end
            // Most episodes end in a finish; some are left open on purpose.
            if (ep < 2 || $urandom_range(0, 7) != 0) begin
                offer(FUNC_FINISH, 7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)),
                      7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)), 16'($urandom),
                      1'b0, ST_OK);
                random_items++;
            end
            if (ep == 2 || $urandom_range(0, 5) == 0)
                wait_results_drained();
            ep++;
        end

        // Drain and let any trailing table walk finish.
        wait_results_drained();
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
